// File: rtl/gdfs_pkg.sv
// shared constants and helpers for the depth-first search block
package gdfs_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int NUM_ROWS     = MAX_VERTICES;
    localparam int VTX_W        = $clog2(NUM_ROWS);
    localparam int CNT_W        = VTX_W + 1;
    localparam int STACK_W      = VTX_W + CNT_W;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [NUM_ROWS-1:0] row_t;
    typedef logic [VTX_W-1:0]    vtx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // lowest set bit of a row, zero when empty
    function automatic vtx_t first_set(input row_t v);
        vtx_t idx;
        idx = '0;
        for (int k = NUM_ROWS - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = VTX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/graph_depth_first_search.sv
// depth-first search spanning tree engine over a small adjacency matrix
//
// usage: an item is taken when start is high and busy is low. command
// CMD_LOAD writes row_bits into adjacency row row_index and answers with a
// single result in the next cycle; busy stays low. command CMD_SEARCH runs a
// depth-first search from root_vertex, trying neighbours in ascending order.
// every tree edge comes out on parent_vertex, child_vertex, child_label with
// edge_valid set, strobed by result_valid for one cycle; the final result of
// an item has last_result set. a search with no tree edge answers with one
// result with edge_valid low.
// sequence: each discovery takes a scan step, which also issues the next row
// read, and each backtrack passes through ST_SCAN and then ST_POP, as the
// registered reads of the adjacency ram and the stack ram require. the
// receiver cannot stall: results must be taken as shown.
// vertex_count is written over the cfg channel while busy is low.
// reset clears all adjacency rows through per-row valid bits, the vertex
// count returns to 16 and the block comes up idle.
module graph_depth_first_search
    import gdfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             command,
    input  logic [VTX_W-1:0] row_index,
    input  logic [NUM_ROWS-1:0] row_bits,
    input  logic [VTX_W-1:0] root_vertex,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             result_valid,
    output logic [VTX_W-1:0] parent_vertex,
    output logic [VTX_W-1:0] child_vertex,
    output logic [CNT_W-1:0] child_label,
    output logic             edge_valid,
    output logic             last_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]   state_reg, state_next;
    cnt_t         vcount_reg;
    row_t         row_valid_reg, row_valid_next;
    logic         row_ok_reg;
    row_t         visited_reg, visited_next;
    cnt_t         depth_reg, depth_next;
    cnt_t         label_reg, label_next;
    vtx_t         top_vertex_reg, top_vertex_next;
    cnt_t         top_next_reg, top_next_next;
    logic         pend_valid_reg, pend_valid_next;
    vtx_t         pend_parent_reg, pend_parent_next;
    vtx_t         pend_child_reg, pend_child_next;
    cnt_t         pend_label_reg, pend_label_next;
    logic         res_valid_reg, res_valid_next;
    vtx_t         res_parent_reg, res_parent_next;
    vtx_t         res_child_reg, res_child_next;
    cnt_t         res_label_reg, res_label_next;
    logic         res_edge_reg, res_edge_next;
    logic         res_last_reg, res_last_next;

    logic         accept;
    cnt_t         n_eff;
    row_t         row_data;
    row_t         cand;
    vtx_t         found_idx;
    cnt_t         top_idx;
    cnt_t         below_idx;

    logic         adj_we;
    logic         adj_re;
    vtx_t         adj_raddr;
    row_t         adj_rdata;
    logic         stk_we;
    logic         stk_re;
    logic [STACK_W-1:0] stk_wdata;
    logic [STACK_W-1:0] stk_rdata;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    assign result_valid  = res_valid_reg;
    assign parent_vertex = res_parent_reg;
    assign child_vertex  = res_child_reg;
    assign child_label   = res_label_reg;
    assign edge_valid    = res_edge_reg;
    assign last_result   = res_last_reg;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (vcount_reg > CNT_W'(NUM_ROWS))
        begin
            n_eff = CNT_W'(NUM_ROWS);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign row_data = adj_rdata & {NUM_ROWS{row_ok_reg}};

    always_comb
    begin
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            cand[k] = row_data[k] && !visited_reg[k]
                      && (CNT_W'(k) >= top_next_reg) && (CNT_W'(k) < n_eff);
        end
    end

    assign found_idx = first_set(cand);
    assign top_idx   = depth_reg - CNT_W'(1);
    assign below_idx = depth_reg - CNT_W'(2);

    assign adj_we    = accept && (command == CMD_LOAD);
    assign stk_wdata = {top_vertex_reg, CNT_W'(found_idx) + CNT_W'(1)};

    always_comb
    begin
        state_next       = state_reg;
        row_valid_next   = row_valid_reg;
        visited_next     = visited_reg;
        depth_next       = depth_reg;
        label_next       = label_reg;
        top_vertex_next  = top_vertex_reg;
        top_next_next    = top_next_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;
        pend_label_next  = pend_label_reg;
        res_valid_next   = 1'b0;
        res_parent_next  = res_parent_reg;
        res_child_next   = res_child_reg;
        res_label_next   = res_label_reg;
        res_edge_next    = res_edge_reg;
        res_last_next    = res_last_reg;
        adj_re           = 1'b0;
        adj_raddr        = top_vertex_reg;
        stk_we           = 1'b0;
        stk_re           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_LOAD)
                begin
                    row_valid_next[row_index] = 1'b1;
                    res_valid_next  = 1'b1;
                    res_parent_next = '0;
                    res_child_next  = '0;
                    res_label_next  = '0;
                    res_edge_next   = 1'b0;
                    res_last_next   = 1'b1;
                end
                else if (accept)
                begin
                    visited_next    = '0;
                    pend_valid_next = 1'b0;
                    if (CNT_W'(root_vertex) < n_eff)
                    begin
                        visited_next[root_vertex] = 1'b1;
                        label_next      = CNT_W'(1);
                        depth_next      = CNT_W'(1);
                        top_vertex_next = root_vertex;
                        top_next_next   = '0;
                        adj_re          = 1'b1;
                        adj_raddr       = root_vertex;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        label_next      = '0;
                        depth_next      = '0;
                        res_valid_next  = 1'b1;
                        res_parent_next = '0;
                        res_child_next  = '0;
                        res_label_next  = '0;
                        res_edge_next   = 1'b0;
                        res_last_next   = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cand != '0)
                begin
                    stk_we                   = 1'b1;
                    visited_next[found_idx]  = 1'b1;
                    label_next               = label_reg + CNT_W'(1);
                    depth_next               = depth_reg + CNT_W'(1);
                    top_vertex_next          = found_idx;
                    top_next_next            = '0;
                    adj_re                   = 1'b1;
                    adj_raddr                = found_idx;
                    if (pend_valid_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_parent_next = pend_parent_reg;
                        res_child_next  = pend_child_reg;
                        res_label_next  = pend_label_reg;
                        res_edge_next   = 1'b1;
                        res_last_next   = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_parent_next = top_vertex_reg;
                    pend_child_next  = found_idx;
                    pend_label_next  = label_reg + CNT_W'(1);
                end
                else if (depth_reg == CNT_W'(1))
                begin
                    depth_next      = '0;
                    pend_valid_next = 1'b0;
                    res_valid_next  = 1'b1;
                    res_parent_next = pend_valid_reg ? pend_parent_reg : '0;
                    res_child_next  = pend_valid_reg ? pend_child_reg : '0;
                    res_label_next  = pend_valid_reg ? pend_label_reg : '0;
                    res_edge_next   = pend_valid_reg;
                    res_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    depth_next = depth_reg - CNT_W'(1);
                    stk_re     = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                top_vertex_next = stk_rdata[STACK_W-1:CNT_W];
                top_next_next   = stk_rdata[CNT_W-1:0];
                adj_re          = 1'b1;
                adj_raddr       = stk_rdata[STACK_W-1:CNT_W];
                state_next      = ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= CNT_W'(MAX_VERTICES);
            row_valid_reg  <= '0;
            row_ok_reg     <= 1'b0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            label_reg      <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            label_reg      <= label_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            if (adj_re)
            begin
                row_ok_reg <= row_valid_reg[adj_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_vertex_reg  <= top_vertex_next;
        top_next_reg    <= top_next_next;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
        pend_label_reg  <= pend_label_next;
        res_parent_reg  <= res_parent_next;
        res_child_reg   <= res_child_next;
        res_label_reg   <= res_label_next;
        res_edge_reg    <= res_edge_next;
        res_last_reg    <= res_last_next;
    end

    // adjacency matrix, one row per source vertex
    gdfs_ram #(
        .WIDTH (NUM_ROWS),
        .DEPTH (NUM_ROWS)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (row_index),
        .wdata (row_bits),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // search stack of vertex and resume point, top entry kept in registers
    gdfs_ram #(
        .WIDTH (STACK_W),
        .DEPTH (NUM_ROWS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (top_idx[VTX_W-1:0]),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (below_idx[VTX_W-1:0]),
        .rdata (stk_rdata)
    );

endmodule

// File: rtl/gdfs_ram.sv
// generic single-write, single-read ram with registered read data
module gdfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/gdfs_checker.sv
// port-level checks for the depth-first search block and their binding
module gdfs_checker
    import gdfs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             command,
    input logic             result_valid,
    input logic [CNT_W-1:0] child_label,
    input logic             edge_valid,
    input logic             last_result
);

    // a load transaction answers with one empty final result next cycle
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_LOAD
        |=> result_valid && last_result && !edge_valid)
    else $error("load transaction not answered");

    // a result without a tree edge always closes its item
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !edge_valid |-> last_result)
    else $error("empty result not marked last");

    // tree edges never carry the root label
    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && edge_valid
        |-> child_label >= CNT_W'(2) && child_label <= CNT_W'(NUM_ROWS))
    else $error("tree edge label out of range");

    // a search ends with its final result as busy drops
    a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last_result)
    else $error("search ended without final result");

endmodule

bind graph_depth_first_search gdfs_checker u_gdfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .child_label  (child_label),
    .edge_valid   (edge_valid),
    .last_result  (last_result)
);
